/* rtl/core/lfu_cache_table_core_macros.svh */
// Assertion macros shared by the cache table RTL.
`ifndef LFU_CACHE_TABLE_CORE_MACROS_SVH
`define LFU_CACHE_TABLE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define LFU_ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition is followed by another in the next cycle.
`define LFU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LFU_ASSERT_PROP(lbl, clk, rst, prop, msg)
`define LFU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/lfu_pkg.sv */
// Shared constants and types of the LFU cache table.
package lfu_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int USE_W    = 32;
   localparam int STAMP_W  = 64;
   localparam int CSR_W    = 5;

   localparam logic [CSR_W-1:0]  CSR_RESET = CSR_W'(16);
   localparam logic [USE_W-1:0]  USE_MAX   = '1;
   localparam logic [DATA_W-1:0] READ_MISS = '1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // One stored cache entry (valid bits live outside the memory).
   typedef struct packed {
      logic [DATA_W-1:0]  key;
      logic [DATA_W-1:0]  value;
      logic [USE_W-1:0]   use_count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Outcome of one pass over the table.
   typedef struct packed {
      logic             match_found;
      logic [IDX_W-1:0] match_idx;
      entry_type        match_entry;
      logic             victim_found;
      logic [IDX_W-1:0] victim_idx;
      logic [DATA_W-1:0] victim_key;
   } scan_type;

endpackage

/* rtl/core/lfu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* rtl/core/lfu_scan.sv */
// Tracks key match and eviction victim while table entries stream past.
module lfu_scan (
   input  logic                          clock,
   input  logic                          clear,
   input  logic                          rec_valid,
   input  logic [lfu_pkg::IDX_W-1:0]     rec_idx,
   input  lfu_pkg::entry_type            rec,
   input  logic [lfu_pkg::DATA_W-1:0]    req_key,
   output lfu_pkg::scan_type             result
);
   import lfu_pkg::*;

   logic             match_found_ff, match_found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   entry_type        match_entry_ff, match_entry_in;
   logic             victim_found_ff, victim_found_in;
   logic [IDX_W-1:0] victim_idx_ff, victim_idx_in;
   entry_type        victim_entry_ff, victim_entry_in;
   logic             rec_older;

   // Lower count wins, then the earlier stamp; strict compare keeps lowest index
   assign rec_older = {rec.use_count, rec.stamp} <
                      {victim_entry_ff.use_count, victim_entry_ff.stamp};

   always_comb begin
      match_found_in  = match_found_ff;
      match_idx_in    = match_idx_ff;
      match_entry_in  = match_entry_ff;
      victim_found_in = victim_found_ff;
      victim_idx_in   = victim_idx_ff;
      victim_entry_in = victim_entry_ff;
      if (clear) begin
         match_found_in  = 1'b0;
         victim_found_in = 1'b0;
      end else if (rec_valid) begin
         // capture the entry holding the key
         if (!match_found_ff && rec.key == req_key) begin
            match_found_in = 1'b1;
            match_idx_in   = rec_idx;
            match_entry_in = rec;
         end
         // keep the least used, least recently counted entry
         if (!victim_found_ff || rec_older) begin
            victim_found_in = 1'b1;
            victim_idx_in   = rec_idx;
            victim_entry_in = rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      match_found_ff  <= match_found_in;
      match_idx_ff    <= match_idx_in;
      match_entry_ff  <= match_entry_in;
      victim_found_ff <= victim_found_in;
      victim_idx_ff   <= victim_idx_in;
      victim_entry_ff <= victim_entry_in;
   end

   assign result.match_found  = match_found_ff;
   assign result.match_idx    = match_idx_ff;
   assign result.match_entry  = match_entry_ff;
   assign result.victim_found = victim_found_ff;
   assign result.victim_idx   = victim_idx_ff;
   assign result.victim_key   = victim_entry_ff.key;

endmodule

/* rtl/core/lfu_cache_table_core.sv */
// Top level of the LFU cache table: control sequencer around the entry memory.
//
// Request channel: a get or put (req_op, req_key, req_value) transfers at a
// clock edge with start high and busy low. busy stays high until the result.
// Result channel: rsp_valid is high for exactly one cycle with rsp_hit,
// rsp_read_value, rsp_evicted and rsp_evicted_key. The receiver cannot
// stall; the result must be taken in that cycle.
// Configuration: csr_we writes csr_wdata into the capacity register in the
// next edge; write it only while busy is low.
// Operation: every request reads all CAPACITY entries from the entry memory,
// one per cycle through its single read port, then decides in S_DECIDE.
// Hits, get misses and puts with zero capacity show the result after the
// S_SCAN, S_DRAIN and S_DECIDE states; puts of a new key pass through
// S_INSERT as well. busy falls in the result cycle, so a new request can
// transfer then, but not before the result of the last one.
// Reset: synchronous, clears valid bits, occupancy and stamp counter and
// sets capacity to 16. The memory contents need no clearing pass.
module lfu_cache_table_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic signed [31:0]          req_key,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic signed [31:0]          rsp_read_value,
   output logic                        rsp_evicted,
   output logic signed [31:0]          rsp_evicted_key,
   input  logic                        csr_we,
   input  logic [lfu_pkg::CSR_W-1:0]   csr_wdata
);
   import lfu_pkg::*;

   `include "lfu_cache_table_core_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_INSERT
   } state_type;

   state_type            state_ff, state_in;
   logic                 req_op_ff, req_op_in;
   logic [DATA_W-1:0]    req_key_ff, req_key_in;
   logic [DATA_W-1:0]    req_value_ff, req_value_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]     rd_tag_ff, rd_tag_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [CSR_W-1:0]     capacity_ff, capacity_in;
   logic [CAPACITY-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]     occupancy_ff, occupancy_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0]    rsp_read_value_ff, rsp_read_value_in;
   logic                 rsp_evicted_ff, rsp_evicted_in;
   logic [DATA_W-1:0]    rsp_evicted_key_ff, rsp_evicted_key_in;

   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   entry_type            mem_wr_entry;
   logic [ENTRY_W-1:0]   mem_rd_data;
   entry_type            mem_rd_entry;
   scan_type             scan;
   logic [CNT_W-1:0]     eff_cap;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;
   entry_type            touched;
   logic                 touch_bumps;

   // Entry memory: one read per scan cycle, at most one write per request
   lfu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_entry),
      .rd_en   (state_ff == S_SCAN),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rd_data)
   );

   assign mem_rd_entry = entry_type'(mem_rd_data);

   // Match and victim search over the streamed entries
   lfu_scan u_scan (
      .clock     (clock),
      .clear     (state_ff == S_IDLE),
      .rec_valid (rd_valid_ff && valid_ff[rd_tag_ff]),
      .rec_idx   (rd_tag_ff),
      .rec       (mem_rd_entry),
      .req_key   (req_key_ff),
      .result    (scan)
   );

   // Clamp the capacity register to the built size
   always_comb begin
      if (32'(capacity_ff) > CAPACITY) begin
         eff_cap = CNT_W'(CAPACITY);
      end else begin
         eff_cap = CNT_W'(capacity_ff);
      end
   end

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Updated entry on a hit: new value for put, bump count unless saturated
   always_comb begin
      touched     = scan.match_entry;
      touch_bumps = scan.match_entry.use_count != USE_MAX;
      if (req_op_ff == OP_PUT) begin
         touched.value = req_value_ff;
      end
      if (touch_bumps) begin
         touched.use_count = scan.match_entry.use_count + USE_W'(1);
         touched.stamp     = stamp_ff;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in           = state_ff;
      req_op_in          = req_op_ff;
      req_key_in         = req_key_ff;
      req_value_in       = req_value_ff;
      rd_idx_in          = rd_idx_ff;
      rd_tag_in          = rd_idx_ff;
      rd_valid_in        = 1'b0;
      capacity_in        = csr_we ? csr_wdata : capacity_ff;
      valid_in           = valid_ff;
      occupancy_in       = occupancy_ff;
      stamp_in           = stamp_ff;
      rsp_valid_in       = 1'b0;
      rsp_hit_in         = rsp_hit_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      mem_wr_en          = 1'b0;
      mem_wr_addr        = scan.match_idx;
      mem_wr_entry       = touched;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_op_in    = req_op;
               req_key_in   = req_key;
               req_value_in = req_value;
               rd_idx_in    = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read per cycle
            rd_valid_in = 1'b1;
            rd_idx_in   = rd_idx_ff + IDX_W'(1);
            if (rd_idx_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            rsp_hit_in         = scan.match_found;
            rsp_read_value_in  = READ_MISS;
            rsp_evicted_in     = 1'b0;
            rsp_evicted_key_in = '0;
            priority if (scan.match_found) begin
               // hit: write back the touched entry
               mem_wr_en = 1'b1;
               if (touch_bumps) begin
                  stamp_in = stamp_ff + STAMP_W'(1);
               end
               if (req_op_ff == OP_GET) begin
                  rsp_read_value_in = scan.match_entry.value;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (req_op_ff == OP_GET || eff_cap == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               // new key: make room if full, then insert
               if (occupancy_ff >= eff_cap && scan.victim_found) begin
                  valid_in[scan.victim_idx] = 1'b0;
                  occupancy_in              = occupancy_ff - CNT_W'(1);
                  rsp_evicted_in            = 1'b1;
                  rsp_evicted_key_in        = scan.victim_key;
               end
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            mem_wr_addr            = free_idx;
            mem_wr_entry.key       = req_key_ff;
            mem_wr_entry.value     = req_value_ff;
            mem_wr_entry.use_count = USE_W'(1);
            mem_wr_entry.stamp     = stamp_ff;
            if (free_found) begin
               mem_wr_en          = 1'b1;
               valid_in[free_idx] = 1'b1;
               occupancy_in       = occupancy_ff + CNT_W'(1);
               stamp_in           = stamp_ff + STAMP_W'(1);
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, table control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_valid_ff  <= 1'b0;
         capacity_ff  <= CSR_RESET;
         valid_ff     <= '0;
         occupancy_ff <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         occupancy_ff <= occupancy_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_op_ff          <= req_op_in;
      req_key_ff         <= req_key_in;
      req_value_ff       <= req_value_in;
      rd_idx_ff          <= rd_idx_in;
      rd_tag_ff          <= rd_tag_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

   `LFU_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted request did not raise busy")
   `LFU_ASSERT_PROP(a_rsp_after_work, clock, reset, rsp_valid |-> $past(busy), "result without a request in flight")
   `LFU_ASSERT_PROP(a_occ_matches, clock, reset, $countones(valid_ff) == 32'(occupancy_ff), "occupancy disagrees with valid bits")
   `LFU_ASSERT_PROP(a_evict_on_miss, clock, reset, rsp_valid && rsp_evicted |-> !rsp_hit && rsp_read_value == READ_MISS, "eviction on a hit or a get")
   `LFU_ASSERT_PROP(a_no_evict_key, clock, reset, rsp_valid && !rsp_evicted |-> rsp_evicted_key == 0, "evicted key set without eviction")

endmodule
